[rtl/core/rea_pkg.sv]
// shared constants for the rms error accumulator
`default_nettype none

package rea_pkg;

	localparam int SAMPLE_PORT_BITS = 24;
	localparam int COUNT_PORT_BITS  = 32;
	localparam int SUM_BITS         = 64;
	localparam int RMS_BITS         = 24;
	localparam int ROOT_BITS        = SUM_BITS / 2;
	localparam int SQ_REM_BITS      = ROOT_BITS + 2;

endpackage

`default_nettype wire

[rtl/core/rms_error_accumulator_unit.sv]
// top level of the rms error accumulator
//
// channel  direction  handshake            payload
// in       receive    in_valid/in_stall    sample_a, sample_b, last
// out      send       out_valid/out_stall  rms_value, saturated, pair_count
//
// sample pairs are taken one per cycle while in_stall is low; each result passes
// from its last pair through the front pipeline, the queue, serial division by
// the count, serial square root and the result register
// a two-entry queue holds finished block totals; in_stall rises only when it is full
// reset clears all control state and the running totals
`default_nettype none

module rms_error_accumulator_unit #(
	parameter int SAMPLE_BITS = 24,
	parameter int COUNT_BITS  = 32
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic [rea_pkg::SAMPLE_PORT_BITS-1:0] sample_a,
	input  wire logic [rea_pkg::SAMPLE_PORT_BITS-1:0] sample_b,
	input  wire logic                                 last,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic [rea_pkg::RMS_BITS-1:0]              rms_value,
	output logic                                      saturated,
	output logic [rea_pkg::COUNT_PORT_BITS-1:0]       pair_count
);
	import rea_pkg::*;

	localparam int REC_BITS = SUM_BITS + COUNT_BITS + 1;

	logic                push;
	logic [REC_BITS-1:0] push_data;
	logic                q_full;
	logic                pop;
	logic [REC_BITS-1:0] pop_data;
	logic                q_not_empty;

	rea_front #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sample_a (sample_a),
		.sample_b (sample_b),
		.last     (last),
		.push     (push),
		.push_data(push_data),
		.q_full   (q_full)
	);

	rea_fifo #(
		.WIDTH(REC_BITS)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (q_full),
		.pop      (pop),
		.pop_data (pop_data),
		.not_empty(q_not_empty)
	);

	rea_back #(
		.COUNT_BITS(COUNT_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_not_empty(q_not_empty),
		.q_data     (pop_data),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.rms_value  (rms_value),
		.saturated  (saturated),
		.pair_count (pair_count)
	);

endmodule

`default_nettype wire

[rtl/core/rea_front.sv]
// front end: difference, square and saturating accumulation per block
`default_nettype none

module rea_front #(
	parameter int SAMPLE_BITS = 24,
	parameter int COUNT_BITS  = 32
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  wire logic [rea_pkg::SAMPLE_PORT_BITS-1:0]   sample_a,
	input  wire logic [rea_pkg::SAMPLE_PORT_BITS-1:0]   sample_b,
	input  wire logic                                   last,
	output logic                                        push,
	output logic [rea_pkg::SUM_BITS+COUNT_BITS:0]       push_data,
	input  wire logic                                   q_full
);
	import rea_pkg::*;

	localparam int SQ_BITS = 2 * SAMPLE_BITS;

	logic                          adv;
	logic signed [SAMPLE_BITS:0]   diff;
	logic [SAMPLE_BITS-1:0]        mag;
	logic                          valid_s1;
	logic                          last_s1;
	logic [SAMPLE_BITS-1:0]        mag_s1;
	logic                          valid_s2;
	logic                          last_s2;
	logic [SQ_BITS-1:0]            sq_s2;
	logic [SUM_BITS-1:0]           sum_q;
	logic [COUNT_BITS-1:0]         tally_q;
	logic                          flag_q;
	logic [SUM_BITS:0]             sum_add;
	logic [SUM_BITS-1:0]           sum_new;
	logic [COUNT_BITS-1:0]         tally_new;
	logic                          flag_new;

	assign adv      = !(valid_s2 && last_s2 && q_full);
	assign in_stall = !adv;

	assign diff = {sample_a[SAMPLE_BITS-1], sample_a[SAMPLE_BITS-1:0]}
	            - {sample_b[SAMPLE_BITS-1], sample_b[SAMPLE_BITS-1:0]};
	assign mag  = diff[SAMPLE_BITS] ? SAMPLE_BITS'(-diff) : diff[SAMPLE_BITS-1:0];

	// saturating sum and count
	assign sum_add   = {1'b0, sum_q} + {{(SUM_BITS + 1 - SQ_BITS){1'b0}}, sq_s2};
	assign sum_new   = sum_add[SUM_BITS] ? {SUM_BITS{1'b1}} : sum_add[SUM_BITS-1:0];
	assign tally_new = (&tally_q) ? tally_q : tally_q + COUNT_BITS'(1);
	assign flag_new  = flag_q || sum_add[SUM_BITS] || (&tally_q);

	assign push      = valid_s2 && last_s2 && adv;
	assign push_data = {flag_new, tally_new, sum_new};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			sum_q    <= '0;
			tally_q  <= '0;
			flag_q   <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			if (valid_s2) begin
				if (last_s2) begin
					sum_q   <= '0;
					tally_q <= '0;
					flag_q  <= 1'b0;
				end else begin
					sum_q   <= sum_new;
					tally_q <= tally_new;
					flag_q  <= flag_new;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s1  <= mag;
			last_s1 <= last;
			sq_s2   <= mag_s1 * mag_s1;
			last_s2 <= last_s1;
		end
	end

endmodule

`default_nettype wire

[rtl/core/rea_fifo.sv]
// two-entry queue of finished block totals
`default_nettype none

module rea_fifo #(
	parameter int WIDTH = 97
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      pop_data,
	output logic                  not_empty
);
	import rea_pkg::*;

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	assign full      = count_q[1];
	assign not_empty = (count_q != 2'd0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			if (push && !pop) count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

endmodule

`default_nettype wire

[rtl/core/rea_back.sv]
// back end: serial divide by the count, serial square root, result register
`default_nettype none

module rea_back #(
	parameter int COUNT_BITS = 32
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 q_not_empty,
	input  wire logic [rea_pkg::SUM_BITS+COUNT_BITS:0] q_data,
	output logic                                      pop,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic [rea_pkg::RMS_BITS-1:0]              rms_value,
	output logic                                      saturated,
	output logic [rea_pkg::COUNT_PORT_BITS-1:0]       pair_count
);
	import rea_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_SQRT = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;
	localparam int CNT_BITS = $clog2(SUM_BITS);

	logic [1:0]             state_q;
	logic [CNT_BITS-1:0]    cnt_q;
	logic [SUM_BITS-1:0]    work_q;
	logic [COUNT_BITS-1:0]  divisor_q;
	logic [COUNT_BITS-1:0]  drem_q;
	logic [ROOT_BITS-1:0]   root_q;
	logic [SQ_REM_BITS-1:0] srem_q;
	logic                   flag_q;
	logic [COUNT_BITS:0]    dsh;
	logic                   dbit;
	logic [SQ_REM_BITS+1:0] ssh;
	logic [SQ_REM_BITS+1:0] trial;
	logic                   sbit;
	logic                   load_out;
	logic [RMS_BITS-1:0]    rms_clamped;

	assign dsh   = {drem_q, work_q[SUM_BITS-1]};
	assign dbit  = (dsh >= {1'b0, divisor_q});
	assign ssh   = {srem_q, work_q[SUM_BITS-1 -: 2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign sbit  = (ssh >= trial);

	assign pop         = (state_q == ST_IDLE) && q_not_empty;
	assign load_out    = (state_q == ST_FIN) && (!out_valid || !out_stall);
	assign rms_clamped = (|root_q[ROOT_BITS-1:RMS_BITS]) ? {RMS_BITS{1'b1}}
	                                                     : root_q[RMS_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (load_out) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (q_not_empty) begin
						state_q <= ST_DIV;
						cnt_q   <= '0;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + CNT_BITS'(1);
					if (&cnt_q) begin
						state_q <= ST_SQRT;
						cnt_q   <= '0;
					end
				end
				ST_SQRT: begin
					cnt_q <= cnt_q + CNT_BITS'(1);
					if (cnt_q == CNT_BITS'(ROOT_BITS - 1)) state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (load_out) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				work_q    <= q_data[SUM_BITS-1:0];
				divisor_q <= q_data[SUM_BITS +: COUNT_BITS];
				flag_q    <= q_data[SUM_BITS+COUNT_BITS];
				drem_q    <= '0;
				root_q    <= '0;
				srem_q    <= '0;
			end
			ST_DIV: begin
				drem_q <= dbit ? COUNT_BITS'(dsh - {1'b0, divisor_q}) : dsh[COUNT_BITS-1:0];
				work_q <= {work_q[SUM_BITS-2:0], dbit};
			end
			ST_SQRT: begin
				srem_q <= sbit ? SQ_REM_BITS'(ssh - trial) : ssh[SQ_REM_BITS-1:0];
				root_q <= {root_q[ROOT_BITS-2:0], sbit};
				work_q <= {work_q[SUM_BITS-3:0], 2'b00};
			end
			default: begin
			end
		endcase
		if (load_out) begin
			rms_value  <= rms_clamped;
			saturated  <= flag_q;
			pair_count <= COUNT_PORT_BITS'(divisor_q);
		end
	end

endmodule

`default_nettype wire

[tb/rms_error_accumulator_unit_tb.sv]
// self-checking testbench for the rms error accumulator unit
module rms_error_accumulator_unit_tb;
	import rea_pkg::*;

	typedef struct packed {
		logic [RMS_BITS-1:0]        rms;
		logic                       sat;
		logic [COUNT_PORT_BITS-1:0] count;
	} rms_result_t;

	typedef enum {PAIR_ANY, PAIR_CORNER, PAIR_CLOSE, PAIR_EQUAL} pair_kind_t;
	typedef enum {STALL_NONE, STALL_RANDOM, STALL_RUNS} stall_mode_t;

	localparam logic [SAMPLE_PORT_BITS-1:0] SAMPLE_MAX = 24'h7F_FFFF;
	localparam logic [SAMPLE_PORT_BITS-1:0] SAMPLE_MIN = 24'h80_0000;
	localparam logic [SAMPLE_PORT_BITS-1:0] SAMPLE_NEG_ONE = 24'hFF_FFFF;

	logic                        clk;
	logic                        arst_n;
	logic                        in_valid;
	logic                        in_stall;
	logic [SAMPLE_PORT_BITS-1:0] sample_a;
	logic [SAMPLE_PORT_BITS-1:0] sample_b;
	logic                        last;
	logic                        out_valid;
	logic                        out_stall;
	logic [RMS_BITS-1:0]         rms_value;
	logic                        saturated;
	logic [COUNT_PORT_BITS-1:0]  pair_count;

	rms_result_t pending_rms_q[$];
	logic [SUM_BITS-1:0]        err_sum;
	logic [COUNT_PORT_BITS-1:0] err_pairs;
	logic                       err_sat;

	int          error_count;
	int          pairs_sent;
	int          burst_left;
	bit          sender_idle_en;
	stall_mode_t stall_mode;
	int          hold_left;

	logic [SAMPLE_PORT_BITS-1:0] corner_values[5] =
		'{SAMPLE_MAX, SAMPLE_MIN, 24'h00_0000, 24'h00_0001, SAMPLE_NEG_ONE};

	rms_error_accumulator_unit i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample_a   (sample_a),
		.sample_b   (sample_b),
		.last       (last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.rms_value  (rms_value),
		.saturated  (saturated),
		.pair_count (pair_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic accumulate_pair(input logic [SAMPLE_PORT_BITS-1:0] a,
		input logic [SAMPLE_PORT_BITS-1:0] b, input logic lst);
		longint              diff;
		logic [SUM_BITS-1:0] mag;
		logic [SUM_BITS-1:0] sq;
		logic [SUM_BITS-1:0] mean;
		logic [31:0]         root;
		logic [31:0]         trial;
		rms_result_t         r;
		diff = longint'(signed'(a)) - longint'(signed'(b));
		mag = (diff < 0) ? -diff : diff;
		sq = mag * mag;
		if (sq > ~err_sum) begin
			err_sum = '1;
			err_sat = 1'b1;
		end else begin
			err_sum = err_sum + sq;
		end
		if (err_pairs == '1) begin
			err_sat = 1'b1;
		end else begin
			err_pairs = err_pairs + 1;
		end
		if (lst) begin
			mean = err_sum / {32'd0, err_pairs};
			root = '0;
			for (int i = 31; i >= 0; i--) begin
				trial = root | (32'd1 << i);
				if ({32'd0, trial} * {32'd0, trial} <= mean)
					root = trial;
			end
			r.rms = (root > 32'h00FF_FFFF) ? 24'hFF_FFFF : root[RMS_BITS-1:0];
			r.sat = err_sat;
			r.count = err_pairs;
			pending_rms_q.push_back(r);
			err_sum = '0;
			err_pairs = '0;
			err_sat = 1'b0;
		end
	endtask

	// one transfer on the input channel, with bursty idling when enabled
	task automatic send_pair(input logic [SAMPLE_PORT_BITS-1:0] a,
		input logic [SAMPLE_PORT_BITS-1:0] b, input logic lst);
		int gap;
		if (sender_idle_en && burst_left == 0) begin
			gap = $urandom_range(1, 6);
			burst_left = $urandom_range(1, 16);
			@(negedge clk);
			in_valid <= 1'b0;
			sample_a <= SAMPLE_PORT_BITS'($urandom);
			sample_b <= SAMPLE_PORT_BITS'($urandom);
			last <= 1'($urandom_range(0, 1));
			repeat (gap - 1) @(negedge clk);
		end
		if (burst_left > 0)
			burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		sample_a <= a;
		sample_b <= b;
		last <= lst;
		do @(posedge clk); while (in_stall);
		accumulate_pair(a, b, lst);
		pairs_sent++;
	endtask

	task automatic set_traffic(input bit idle_en, input stall_mode_t mode);
		@(negedge clk);
		in_valid <= 1'b0;
		sender_idle_en = idle_en;
		burst_left = 0;
		stall_mode = mode;
	endtask

	function automatic void pick_pair(input pair_kind_t kind,
		output logic [SAMPLE_PORT_BITS-1:0] a, output logic [SAMPLE_PORT_BITS-1:0] b);
		case (kind)
			PAIR_CORNER: begin
				a = corner_values[3'($urandom_range(0, 4))];
				b = corner_values[3'($urandom_range(0, 4))];
			end
			PAIR_CLOSE: begin
				a = SAMPLE_PORT_BITS'($urandom);
				b = SAMPLE_PORT_BITS'(a + $urandom_range(0, 64) - 32);
			end
			PAIR_EQUAL: begin
				a = SAMPLE_PORT_BITS'($urandom);
				b = a;
			end
			default: begin
				a = SAMPLE_PORT_BITS'($urandom);
				b = SAMPLE_PORT_BITS'($urandom);
			end
		endcase
	endfunction

	task automatic test_directed;
		set_traffic(1'b0, STALL_NONE);
		send_pair(24'h00_0000, 24'h00_0000, 1'b1);
		send_pair(SAMPLE_MAX, SAMPLE_MIN, 1'b1);
		send_pair(SAMPLE_MIN, SAMPLE_MAX, 1'b1);
		send_pair(SAMPLE_MIN, SAMPLE_MIN, 1'b1);
		send_pair(SAMPLE_MAX, SAMPLE_MAX, 1'b1);
		send_pair(24'h00_0001, 24'h00_0000, 1'b1);
		send_pair(SAMPLE_NEG_ONE, 24'h00_0001, 1'b1);
		send_pair(SAMPLE_MAX, 24'h00_0000, 1'b0);
		send_pair(24'h00_0000, SAMPLE_MIN, 1'b0);
		send_pair(SAMPLE_NEG_ONE, 24'h00_0000, 1'b1);
		send_pair(24'h00_0000, 24'h00_0000, 1'b0);
		send_pair(24'h00_0000, 24'h00_0000, 1'b0);
		send_pair(24'h00_0003, 24'h00_0000, 1'b1);
		send_pair(24'h55_5555, 24'hAA_AAAA, 1'b0);
		send_pair(24'hAA_AAAA, 24'h55_5555, 1'b1);
	endtask

	// long block of the largest squares
	task automatic test_full_scale;
		set_traffic(1'b0, STALL_NONE);
		for (int i = 0; i < 200; i++) begin
			if (i % 2 == 0)
				send_pair(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
			else
				send_pair(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
		end
		send_pair(SAMPLE_MAX, SAMPLE_MIN, 1'b1);
		send_pair(24'h00_0010, 24'h00_0000, 1'b1);
	endtask

	// receiver holds off long enough that the result queue fills and the input stalls
	task automatic test_backpressure;
		logic [SAMPLE_PORT_BITS-1:0] a;
		logic [SAMPLE_PORT_BITS-1:0] b;
		set_traffic(1'b0, STALL_NONE);
		hold_left = 1500;
		for (int i = 0; i < 60; i++) begin
			pick_pair(PAIR_ANY, a, b);
			send_pair(a, b, (i % 3 == 2) || (i >= 30));
		end
	endtask

	task automatic test_random_blocks;
		logic [SAMPLE_PORT_BITS-1:0] a;
		logic [SAMPLE_PORT_BITS-1:0] b;
		int         len;
		int         sel;
		int         target;
		bit         mixed;
		pair_kind_t kind;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: set_traffic(1'b0, STALL_NONE);
				1: set_traffic(1'b1, STALL_NONE);
				2: set_traffic(1'b0, STALL_RUNS);
				default: set_traffic(1'b1, STALL_RANDOM);
			endcase
			target = pairs_sent + 350;
			while (pairs_sent < target) begin
				sel = $urandom_range(0, 99);
				if (sel < 10)
					len = 1;
				else if (sel < 85)
					len = $urandom_range(2, 24);
				else if (sel < 97)
					len = $urandom_range(25, 80);
				else
					len = $urandom_range(150, 300);
				mixed = ($urandom_range(0, 9) == 0);
				kind = pair_kind_t'($urandom_range(0, 3));
				for (int i = 0; i < len; i++) begin
					if (mixed)
						kind = pair_kind_t'($urandom_range(0, 3));
					pick_pair(kind, a, b);
					send_pair(a, b, i == len - 1);
				end
			end
		end
	endtask

	initial begin
		out_stall = 1'b0;
		forever begin
			bit run_stall;
			int run_left;
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				case (stall_mode)
					STALL_RANDOM: out_stall <= ($urandom_range(0, 99) < 35);
					STALL_RUNS: begin
						if (run_left <= 0) begin
							run_stall = !run_stall;
							run_left = run_stall ? $urandom_range(1, 12) : $urandom_range(1, 6);
						end
						run_left--;
						out_stall <= run_stall;
					end
					default: out_stall <= 1'b0;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		rms_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_rms_q.size() == 0) begin
				error_count++;
				$display("%0t: unexpected result rms %0d sat %0d count %0d", $time,
					rms_value, saturated, pair_count);
			end else begin
				want = pending_rms_q.pop_front();
				if (rms_value !== want.rms) begin
					error_count++;
					$display("%0t: rms_value expected %0d actual %0d", $time, want.rms,
						rms_value);
				end
				if (saturated !== want.sat) begin
					error_count++;
					$display("%0t: saturated expected %0d actual %0d", $time, want.sat,
						saturated);
				end
				if (pair_count !== want.count) begin
					error_count++;
					$display("%0t: pair_count expected %0d actual %0d", $time, want.count,
						pair_count);
				end
			end
		end
	end

	initial begin
		#5000000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		sample_a = '0;
		sample_b = '0;
		last = 1'b0;
		err_sum = '0;
		err_pairs = '0;
		err_sat = 1'b0;
		error_count = 0;
		pairs_sent = 0;
		burst_left = 0;
		sender_idle_en = 1'b0;
		stall_mode = STALL_NONE;
		hold_left = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_full_scale();
		test_backpressure();
		test_random_blocks();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_rms_q.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

[rms_error_accumulator_unit.f]
rtl/core/rea_pkg.sv
rtl/core/rea_front.sv
rtl/core/rea_fifo.sv
rtl/core/rea_back.sv
rtl/core/rms_error_accumulator_unit.sv
tb/rms_error_accumulator_unit_tb.sv
